@@ rtl/file_type_pattern_classifier_assert.svh @@
// assertion macros shared by the classifier rtl
// no dependencies; taken in by include inside module bodies
`ifndef FILE_TYPE_PATTERN_CLASSIFIER_ASSERT_SVH
`define FILE_TYPE_PATTERN_CLASSIFIER_ASSERT_SVH

// same-cycle implication, checked on rising clk, off while in reset
`define FTPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on rising clk, off while in reset
`define FTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ftpc_pkg.sv @@
// types, pattern tables and helper functions of the file type classifier
// no dependencies
package ftpc_pkg;

  localparam int NUM_PAT    = 12;
  localparam int HIST_DEPTH = 4;
  localparam int WIN_LEN    = HIST_DEPTH + 1;

  typedef enum logic [3:0] {
    TC_HTML    = 4'd0,
    TC_GIF     = 4'd1,
    TC_TEXT    = 4'd2,
    TC_JPEG    = 4'd3,
    TC_FLASH   = 4'd4,
    TC_MPEG    = 4'd5,
    TC_PDF     = 4'd6,
    TC_CGI     = 4'd7,
    TC_UNKNOWN = 4'd8
  } type_code_t;

  typedef logic [7:0]                 byte_t;
  typedef logic [WIN_LEN-1:0][7:0]    win_t;
  typedef logic [NUM_PAT-1:0]         pat_mask_t;
  typedef logic [2:0]                 pat_len_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // index 0 holds the last character of each pattern
  localparam win_t PAT_CHAR [NUM_PAT] = '{
    {8'h00, ".htm"}, {8'h00, ".gif"}, ".text", {8'h00, ".txt"},
    ".jpeg",         {8'h00, ".jpg"}, {8'h00, ".swf"}, ".mpeg",
    {8'h00, ".mpg"}, {8'h00, ".pdf"}, {8'h00, ".cgi"}, {8'h00, ".CGI"}
  };

  localparam pat_len_t PAT_LEN [NUM_PAT] = '{
    3'd4, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4
  };

  localparam type_code_t PAT_CODE [NUM_PAT] = '{
    TC_HTML, TC_GIF, TC_TEXT, TC_TEXT, TC_JPEG, TC_JPEG,
    TC_FLASH, TC_MPEG, TC_MPEG, TC_PDF, TC_CGI, TC_CGI
  };

  function automatic pat_mask_t pat_hits(input win_t win);
    pat_mask_t hits;
    hits = '1;
    for (int p = 0; p < NUM_PAT; p++) begin
      for (int k = 0; k < WIN_LEN; k++) begin
        if ((k < int'(PAT_LEN[p])) && (win[k] != PAT_CHAR[p][k])) begin
          hits[p] = 1'b0;
        end
      end
    end
    return hits;
  endfunction

  // lowest set bit wins, codes rise with pattern index
  function automatic type_code_t pick_code(input pat_mask_t seen);
    type_code_t best;
    best = TC_UNKNOWN;
    for (int p = NUM_PAT - 1; p >= 0; p--) begin
      if (seen[p]) begin
        best = PAT_CODE[p];
      end
    end
    return best;
  endfunction

endpackage

@@ rtl/ftpc_if.sv @@
// valid/ready channel interfaces for name bytes and type codes
// depends on ftpc_pkg
interface ftpc_in_if import ftpc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t name_byte;
  logic  last_byte;

  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface ftpc_out_if import ftpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] type_code;

  modport source (output valid, output type_code, input ready);
  modport sink   (input valid, input type_code, output ready);
endinterface

@@ rtl/ftpc_cell.sv @@
// one byte cell of the recent-byte chain
// depends on ftpc_pkg
module ftpc_cell import ftpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  byte_t     din,
  output byte_t     dout
);

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift) begin
      byte_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign dout = byte_r;

endmodule

@@ rtl/file_type_pattern_classifier.sv @@
// top level of the file type classifier: cell chain, match flags, result register
// depends on ftpc_pkg, ftpc_if, ftpc_cell and the assertion macro header

// Takes a file name one byte per item and gives one type code on the item
// that carries last_byte: 0 html, 1 gif, 2 text, 3 jpeg, 4 flash, 5 mpeg,
// 6 pdf, 7 cgi, 8 unknown. A zero byte ends the name; later bytes are
// ignored until the last mark, after which all state clears. Each byte is
// compared against the four bytes held in the cell chain and the sticky
// flags are updated in the same cycle, so an item can be accepted on every
// clock while the output register, which holds the type code, is empty or
// being emptied.
module file_type_pattern_classifier import ftpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ftpc_in_if.sink    in_ch,
  ftpc_out_if.source out_ch
);

  logic       in_fire;
  logic       name_end;
  cell_ctl_t  cell_ctl;
  byte_t      hist [HIST_DEPTH+1];
  win_t       win;
  pat_mask_t  seen_r;
  pat_mask_t  seen_nxt;
  pat_mask_t  seen_upd;
  logic       ended_r;
  logic       ended_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  type_code_t out_code_r;
  type_code_t out_code_nxt;
  logic       take_byte;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign name_end    = in_fire && in_ch.last_byte;
  assign take_byte   = in_fire && !ended_r && (in_ch.name_byte != '0);

  assign cell_ctl.shift = take_byte;
  assign cell_ctl.clear = name_end;

  assign hist[0] = in_ch.name_byte;

  for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
    ftpc_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (cell_ctl),
      .din  (hist[i]),
      .dout (hist[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < WIN_LEN; k++) begin
      win[k] = hist[k];
    end
  end

  always_comb begin
    seen_upd = seen_r;
    if (take_byte) begin
      seen_upd = seen_r | pat_hits(win);
    end
    seen_nxt  = name_end ? '0 : seen_upd;
    ended_nxt = ended_r;
    if (name_end) begin
      ended_nxt = 1'b0;
    end else if (in_fire && (in_ch.name_byte == '0)) begin
      ended_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    if (name_end) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = pick_code(seen_upd);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.type_code = out_code_r;

  `include "file_type_pattern_classifier_assert.svh"

  `FTPC_ASSERT_NEXT(a_end_gives_item, clk, rst_n, name_end, out_valid_r,
    "no type code after last byte")
  `FTPC_ASSERT_NEXT(a_end_clears_state, clk, rst_n, name_end,
    (seen_r == '0) && !ended_r && (hist[1] == '0), "state not cleared after name")
  `FTPC_ASSERT_NOW(a_no_spurious_item, clk, rst_n, $rose(out_valid_r),
    $past(name_end), "type code without a last byte")
  `FTPC_ASSERT_NEXT(a_ended_holds, clk, rst_n, ended_r && !name_end,
    $stable(seen_r) && $stable(hist[1]), "state changed after zero byte")

endmodule

@@ dv/ftpc_code_checker.sv @@
// checker for the file type classifier: follows name items, predicts type codes, compares
// depends on ftpc_pkg; sees the channels as plain signals wired up by the testbench top
module ftpc_code_checker import ftpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  byte_t      in_name_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_type_code,
  output int         fail_count,
  output int         codes_pending
);

  localparam int N_SUFFIX = 12;

  string suffix_text [N_SUFFIX] = '{
    ".htm", ".gif", ".text", ".txt", ".jpeg", ".jpg",
    ".swf", ".mpeg", ".mpg", ".pdf", ".cgi", ".CGI"
  };

  type_code_t suffix_code [N_SUFFIX] = '{
    TC_HTML, TC_GIF, TC_TEXT, TC_TEXT, TC_JPEG, TC_JPEG,
    TC_FLASH, TC_MPEG, TC_MPEG, TC_PDF, TC_CGI, TC_CGI
  };

  byte_t                tail_bytes [4];
  logic [N_SUFFIX-1:0]  suffix_seen;
  logic                 name_done;
  type_code_t           expected_codes [$];
  int                   codes_taken;

  function automatic bit suffix_ends_at(int p, byte_t b);
    string s;
    int    n;
    s = suffix_text[p];
    n = s.len();
    if (byte_t'(s[n-1]) != b) return 1'b0;
    for (int k = 1; k < n; k++) begin
      if (byte_t'(s[n-1-k]) != tail_bytes[k-1]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic type_code_t winning_code(logic [N_SUFFIX-1:0] seen);
    type_code_t best;
    best = TC_UNKNOWN;
    for (int p = 0; p < N_SUFFIX; p++) begin
      if (seen[p] && (suffix_code[p] < best)) best = suffix_code[p];
    end
    return best;
  endfunction

  task automatic clear_name();
    for (int k = 0; k < 4; k++) tail_bytes[k] = '0;
    suffix_seen = '0;
    name_done   = 1'b0;
  endtask

  task automatic absorb_name_byte(byte_t b, logic last);
    if (!name_done) begin
      if (b == 8'h00) begin
        name_done = 1'b1;
      end else begin
        for (int p = 0; p < N_SUFFIX; p++) begin
          if (suffix_ends_at(p, b)) suffix_seen[p] = 1'b1;
        end
        for (int k = 3; k > 0; k--) tail_bytes[k] = tail_bytes[k-1];
        tail_bytes[0] = b;
      end
    end
    if (last) begin
      expected_codes.push_back(winning_code(suffix_seen));
      clear_name();
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at code %0d: %s (got %0d, want %0d)", codes_taken, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_name();
      expected_codes.delete();
      codes_taken = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch("type code with no name pending", int'(out_type_code), -1);
        end else if (out_type_code !== 4'(expected_codes[0])) begin
          report_mismatch("type_code", int'(out_type_code), int'(expected_codes[0]));
          void'(expected_codes.pop_front());
        end else begin
          void'(expected_codes.pop_front());
        end
        codes_taken++;
      end
      if (in_valid && in_ready) absorb_name_byte(in_name_byte, in_last_byte);
    end
    codes_pending = expected_codes.size();
  end

endmodule

@@ dv/testbench.sv @@
// testbench top for the file type classifier: clock, reset, name stimulus, result sink, verdict
// depends on ftpc_pkg, ftpc_if, the classifier rtl and ftpc_code_checker
module testbench;
  import ftpc_pkg::*;

  localparam int CLK_HI       = 6;
  localparam int CLK_LO       = 6;
  localparam int RESET_CYCLES = 8;
  localparam int NAME_ITEMS   = 1350;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   codes_pending;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  int   stall_left = 0;
  bit   calm = 1'b0;
  bit   drained_once = 1'b0;

  string name_suffixes [12] = '{
    ".htm", ".gif", ".text", ".txt", ".jpeg", ".jpg",
    ".swf", ".mpeg", ".mpg", ".pdf", ".cgi", ".CGI"
  };
  string name_alphabet = ".htmgifextjpswpdcCGI.";

  ftpc_in_if  name_ch ();
  ftpc_out_if code_ch ();

  file_type_pattern_classifier u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (name_ch),
    .out_ch (code_ch)
  );

  ftpc_code_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (name_ch.valid),
    .in_ready      (name_ch.ready),
    .in_name_byte  (name_ch.name_byte),
    .in_last_byte  (name_ch.last_byte),
    .out_valid     (code_ch.valid),
    .out_ready     (code_ch.ready),
    .out_type_code (code_ch.type_code),
    .fail_count    (fail_count),
    .codes_pending (codes_pending)
  );

  always begin
    #CLK_HI clk = 1'b1;
    #CLK_LO clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result sink with bursts of back-pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 2) * 12;
    if (calm || !rst_n) begin
      code_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      code_ch.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      code_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      code_ch.ready = 1'b1;
    end
  end

  task automatic send_item(byte_t b, logic last);
    int gap;
    if (!calm && ($urandom_range(0, 99) < gap_pct)) begin
      gap = $urandom_range(1, 8);
      name_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    name_ch.valid     = 1'b1;
    name_ch.name_byte = b;
    name_ch.last_byte = last;
    do @(posedge clk); while (!name_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit mark_last);
    for (int i = 0; i < s.len(); i++) begin
      send_item(byte_t'(s[i]), mark_last && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    name_ch.valid = 1'b0;
    while (codes_pending != 0) @(negedge clk);
  endtask

  function automatic byte_t name_char();
    if ($urandom_range(0, 3) != 0) begin
      return byte_t'(name_alphabet[$urandom_range(0, name_alphabet.len() - 1)]);
    end
    return byte_t'($urandom_range(1, 255));
  endfunction

  task automatic send_random_name();
    int    count;
    string piece;
    int    idx;
    if ($urandom_range(0, 9) == 0) begin
      // noise and zeros anywhere, a mark at most on the last byte
      count = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
        send_item(byte_t'($urandom_range(0, 255)), (i == count - 1) && $urandom_range(0, 1));
      end
    end else begin
      count = $urandom_range(0, 4);
      for (int i = 0; i < count; i++) send_item(name_char(), 1'b0);
      count = $urandom_range(0, 2);
      for (int i = 0; i < count; i++) begin
        piece = name_suffixes[$urandom_range(0, 11)];
        if ($urandom_range(0, 4) == 0) begin
          idx = $urandom_range(0, piece.len() - 1);
          piece[idx] = name_char();
        end
        send_text(piece, 1'b0);
        if ($urandom_range(0, 1)) send_item(name_char(), 1'b0);
      end
      case ($urandom_range(0, 2))
        0: begin
          send_item(name_char(), 1'b1);
        end
        1: begin
          send_item(8'h00, 1'b1);
        end
        default: begin
          send_item(8'h00, 1'b0);
          count = $urandom_range(1, 3);
          for (int i = 0; i < count; i++) begin
            send_item(byte_t'($urandom_range(0, 255)), i == count - 1);
          end
        end
      endcase
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    name_ch.valid     = 1'b0;
    name_ch.name_byte = 8'h00;
    name_ch.last_byte = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    send_text(".htm", 1'b1);
    wait_drained();
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);
    send_text(".jpg.gif", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h2e, 1'b0);
    send_item(8'h41, 1'b1);
    send_text(".CGI", 1'b1);
    send_text("a.text", 1'b1);

    while (items_sent < NAME_ITEMS) begin
      if (items_sent >= NAME_ITEMS * 85 / 100) calm = 1'b1;
      if (!drained_once && (items_sent >= NAME_ITEMS / 2)) begin
        wait_drained();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) gap_pct = $urandom_range(0, 2) * 15;
      send_random_name();
    end

    name_ch.valid = 1'b0;
    while (codes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if ((fail_count == 0) && (codes_pending == 0)) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
